// File: rtl/core/dpidtc_pkg.sv
package dpidtc_pkg;

    // field and state widths
    localparam int MEAS_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int ERR_W     = MEAS_W + 1;
    localparam int DER_W     = ERR_W + 1;
    localparam int SUM_W     = 32;
    localparam int FRAC_BITS = 8;
    localparam int LEVEL_W   = 7;
    localparam int LEVEL_MAX = 100;

    // integral is kept only while |error| is above this band
    localparam int INTEGRAL_BAND = 3;

    // product widths and the width of their sum
    localparam int PP_W    = GAIN_W + ERR_W;
    localparam int PI_W    = GAIN_W + SUM_W;
    localparam int PD_W    = GAIN_W + DER_W;
    localparam int TOTAL_W = PI_W + 2;

    // configuration register file
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_KP     = 3'd0,
        CFG_DRIVE_KI     = 3'd1,
        CFG_DRIVE_KD     = 3'd2,
        CFG_TURN_KP      = 3'd3,
        CFG_TURN_KI      = 3'd4,
        CFG_TURN_KD      = 3'd5,
        CFG_DRIVE_TARGET = 3'd6,
        CFG_TURN_TARGET  = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        CH_DRIVE = 1'b0,
        CH_TURN  = 1'b1
    } t_channel;

endpackage

// File: rtl/core/dual_pid_drive_turn_controller.sv
// channel  | handshake                 | payload
// ---------+---------------------------+---------------------------------------
// input    | i_valid / o_ready         | i_channel, i_measurement
// output   | o_valid / i_ready         | o_drive_level, o_at_target
// config   | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// single pass: an input register, then error, integral, the three products and
// the clamp in one combinational step into the result register
// o_valid rises as an item moves from the input register to the result register;
// one transaction per cycle sustained while i_ready stays high
// loop state updates as an item moves into the result register, so back to back
// samples on the same loop see fresh state
// synchronous active low reset clears gains, targets, loop state and valids
// a stall on the output holds the result, one more transaction parks in the
// input register, and then o_ready drops
module dual_pid_drive_turn_controller
    import dpidtc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_channel,
    input  logic signed [MEAS_W-1:0]  i_measurement,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [LEVEL_W-1:0]        o_drive_level,
    output logic                      o_at_target
);

    // configuration registers
    logic [CFG_W-1:0] r_cfg [CFG_NUM];

    // loop state
    logic signed [ERR_W-1:0] r_drive_last, r_turn_last;
    logic signed [SUM_W-1:0] r_drive_sum, r_turn_sum;

    // input register
    logic                     r_in_v;
    logic                     r_in_ch;
    logic signed [MEAS_W-1:0] r_in_meas;

    // result register
    logic               r_out_v;
    logic [LEVEL_W-1:0] r_level;
    logic               r_zero;

    // flow control
    logic w_out_rdy, w_in_rdy;
    logic w_accept, w_move;

    // error, derivative and integral
    logic signed [MEAS_W-1:0] w_target;
    logic signed [ERR_W-1:0]  w_last;
    logic signed [SUM_W-1:0]  w_sum_old;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [DER_W-1:0]  n_der;
    logic signed [SUM_W:0]    w_sum_ext;
    logic signed [SUM_W-1:0]  w_sum_sat;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [ERR_W-1:0]  w_band_pos, w_band_neg;
    logic                     w_out_band;
    logic                     n_zero;

    // products, sum and clamp
    logic signed [GAIN_W-1:0]  w_kp, w_ki, w_kd;
    logic signed [PP_W-1:0]    w_pp;
    logic signed [PI_W-1:0]    w_pi;
    logic signed [PD_W-1:0]    w_pd;
    logic signed [TOTAL_W-1:0] w_total;
    logic signed [TOTAL_W-1:0] w_total_lim;
    logic [LEVEL_W-1:0]        n_level;

    // the result register takes data when empty or draining, the input
    // register when empty or handing its item on
    assign w_out_rdy = !r_out_v || i_ready;
    assign w_in_rdy  = !r_in_v || w_out_rdy;
    assign o_ready   = w_in_rdy;
    assign w_accept  = i_valid && w_in_rdy;
    assign w_move    = r_in_v && w_out_rdy;

    // error, derivative and integral for the selected loop
    always_comb begin
        w_target  = (r_in_ch == CH_TURN) ? $signed(r_cfg[CFG_TURN_TARGET])
                                         : $signed(r_cfg[CFG_DRIVE_TARGET]);
        w_last    = (r_in_ch == CH_TURN) ? r_turn_last : r_drive_last;
        w_sum_old = (r_in_ch == CH_TURN) ? r_turn_sum : r_drive_sum;

        n_err  = ERR_W'(w_target) - ERR_W'(r_in_meas);
        n_der  = DER_W'(n_err) - DER_W'(w_last);
        n_zero = (n_err == '0);

        w_band_pos = ERR_W'(INTEGRAL_BAND);
        w_band_neg = -w_band_pos;
        w_out_band = (n_err > w_band_pos) || (n_err < w_band_neg);

        // saturating accumulate: top two bits disagree on overflow
        w_sum_ext = (SUM_W+1)'(w_sum_old) + (SUM_W+1)'(n_err);
        if (w_sum_ext[SUM_W] != w_sum_ext[SUM_W-1]) begin
            w_sum_sat = w_sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_sum_sat = w_sum_ext[SUM_W-1:0];
        end
        n_sum = w_out_band ? w_sum_sat : '0;
    end

    // gain products
    always_comb begin
        w_kp = (r_in_ch == CH_TURN) ? $signed(r_cfg[CFG_TURN_KP])
                                    : $signed(r_cfg[CFG_DRIVE_KP]);
        w_ki = (r_in_ch == CH_TURN) ? $signed(r_cfg[CFG_TURN_KI])
                                    : $signed(r_cfg[CFG_DRIVE_KI]);
        w_kd = (r_in_ch == CH_TURN) ? $signed(r_cfg[CFG_TURN_KD])
                                    : $signed(r_cfg[CFG_DRIVE_KD]);
        w_pp = PP_W'(w_kp) * PP_W'(n_err);
        w_pi = PI_W'(w_ki) * PI_W'(n_sum);
        w_pd = PD_W'(w_kd) * PD_W'(n_der);
    end

    // sum of terms, drop the gain fraction and clamp to 0..LEVEL_MAX
    always_comb begin
        w_total     = TOTAL_W'(w_pp) + TOTAL_W'(w_pi) + TOTAL_W'(w_pd);
        w_total_lim = TOTAL_W'((LEVEL_MAX + 1) * (2 ** FRAC_BITS));
        if (w_total <= 0) begin
            n_level = '0;
        end else if (w_total >= w_total_lim) begin
            n_level = LEVEL_W'(LEVEL_MAX);
        end else begin
            n_level = w_total[FRAC_BITS +: LEVEL_W];
        end
    end

    // control and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= '0;
            end
            r_drive_last <= '0;
            r_turn_last  <= '0;
            r_drive_sum  <= '0;
            r_turn_sum   <= '0;
            r_in_v       <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            if (w_move) begin
                if (r_in_ch == CH_TURN) begin
                    r_turn_last <= n_err;
                    r_turn_sum  <= n_sum;
                end else begin
                    r_drive_last <= n_err;
                    r_drive_sum  <= n_sum;
                end
            end
            if (w_in_rdy) begin
                r_in_v <= i_valid;
            end
            if (w_out_rdy) begin
                r_out_v <= r_in_v;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_ch   <= i_channel;
            r_in_meas <= i_measurement;
        end
        if (w_move) begin
            r_level <= n_level;
            r_zero  <= n_zero;
        end
    end

    assign o_valid       = r_out_v;
    assign o_drive_level = r_level;
    assign o_at_target   = r_zero;

    // a nonzero integral means the last error was outside the band
    a_drive_sum_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drive_sum != '0) |-> ((r_drive_last > w_band_pos) || (r_drive_last < w_band_neg)))
        else $error("drive integral held inside band");

    a_turn_sum_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_turn_sum != '0) |-> ((r_turn_last > w_band_pos) || (r_turn_last < w_band_neg)))
        else $error("turn integral held inside band");

    // an in-band sample on the drive loop clears its integral
    a_drive_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && (r_in_ch == CH_DRIVE) && !w_out_band) |=> (r_drive_sum == '0))
        else $error("drive integral not cleared");

    // level never leaves its clamp range
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_drive_level <= LEVEL_W'(LEVEL_MAX)))
        else $error("level above clamp");

    // the result register empties only through a transaction
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready) |=> r_out_v)
        else $error("output lost while stalled");

endmodule

// File: dv/pid_level_checker.sv
module pid_level_checker
    import dpidtc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_channel,
    input  logic signed [MEAS_W-1:0] i_measurement,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [LEVEL_W-1:0]       i_drive_level,
    input  logic                     i_at_target,
    output int                       o_mismatches = 0,
    output int                       o_outstanding = 0
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               hit;
    } t_level_result;

    logic signed [CFG_W-1:0] cfg_shadow [CFG_NUM];
    logic signed [ERR_W-1:0] last_error [2];
    logic signed [SUM_W-1:0] error_sum  [2];

    t_level_result expected_levels [$];
    t_level_result oldest_level;
    t_level_result next_level;
    int            mismatch_count = 0;

    // one control step of the selected loop; updates that loop's history
    function automatic t_level_result pid_level_step(input t_channel ch,
                                                     input logic signed [MEAS_W-1:0] meas);
        t_level_result res;
        longint kp, ki, kd, tgt, err, der, mag, acc, total;
        if (ch == CH_DRIVE) begin
            kp  = cfg_shadow[CFG_DRIVE_KP];
            ki  = cfg_shadow[CFG_DRIVE_KI];
            kd  = cfg_shadow[CFG_DRIVE_KD];
            tgt = cfg_shadow[CFG_DRIVE_TARGET];
        end else begin
            kp  = cfg_shadow[CFG_TURN_KP];
            ki  = cfg_shadow[CFG_TURN_KI];
            kd  = cfg_shadow[CFG_TURN_KD];
            tgt = cfg_shadow[CFG_TURN_TARGET];
        end
        err = tgt - longint'(meas);
        der = err - longint'(last_error[ch]);
        mag = (err < 0) ? -err : err;
        // integrate only outside the band, saturating at the sum width
        if (mag > INTEGRAL_BAND) begin
            acc = longint'(error_sum[ch]) + err;
            if (acc > SUM_HI) acc = SUM_HI;
            if (acc < SUM_LO) acc = SUM_LO;
        end else begin
            acc = 0;
        end
        error_sum[ch]  = acc[SUM_W-1:0];
        last_error[ch] = err[ERR_W-1:0];
        total   = kp * err + ki * acc + kd * der;
        res.hit = (err == 0);
        if (total <= 0) begin
            res.level = '0;
        end else begin
            total = total >>> FRAC_BITS;
            if (total > LEVEL_MAX) total = LEVEL_MAX;
            res.level = total[LEVEL_W-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_NUM; k++) cfg_shadow[k] = '0;
            for (int k = 0; k < 2; k++) begin
                last_error[k] = '0;
                error_sum[k]  = '0;
            end
            expected_levels.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) cfg_shadow[i_cfg_idx] = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (expected_levels.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual level %0d at_target %0b",
                             $time, i_drive_level, i_at_target);
                end else begin
                    oldest_level = expected_levels.pop_front();
                    if (i_drive_level !== oldest_level.level) begin
                        mismatch_count++;
                        $display("%0t: drive_level mismatch, expected %0d, actual %0d",
                                 $time, oldest_level.level, i_drive_level);
                    end
                    if (i_at_target !== oldest_level.hit) begin
                        mismatch_count++;
                        $display("%0t: at_target mismatch, expected %0b, actual %0b",
                                 $time, oldest_level.hit, i_at_target);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                next_level      = pid_level_step(t_channel'(i_channel), i_measurement);
                expected_levels = {expected_levels, next_level};
            end
            o_outstanding <= expected_levels.size();
        end
        o_mismatches <= mismatch_count;
    end

endmodule

// File: dv/tb_top.sv
module tb_top
    import dpidtc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SAT_PAIRS     = 100;     // full scale error pushes on both loops
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int BURST_ITEMS   = 60;
    localparam int SETTLE_CYCLES = 8;       // margin beyond the two register pass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_channel;
    logic signed [MEAS_W-1:0]  i_measurement;
    logic                      o_valid;
    logic                      i_ready;
    logic [LEVEL_W-1:0]        o_drive_level;
    logic                      o_at_target;

    int mismatches;
    int outstanding;
    int cycle_count = 0;

    // stimulus controls shared with the receiver process
    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;

    // register values for the next configuration phase
    logic [CFG_W-1:0] cfg_plan [CFG_NUM];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    dual_pid_drive_turn_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_channel     (i_channel),
        .i_measurement (i_measurement),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_drive_level (o_drive_level),
        .o_at_target   (o_at_target)
    );

    pid_level_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_channel     (i_channel),
        .i_measurement (i_measurement),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_drive_level (o_drive_level),
        .i_at_target   (o_at_target),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // watchdog: a hung handshake or a missing result ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL dual_pid_drive_turn_controller");
            $finish;
        end
    end

    // offer one transaction and hold it until the block takes it
    task automatic send_sample(input t_channel ch, input logic [MEAS_W-1:0] meas);
        i_valid       <= 1'b1;
        i_channel     <= ch;
        i_measurement <= meas;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // random sender gap, skipped in the quiet stretches
    task automatic maybe_gap();
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the whole register file, one register per cycle
    task automatic apply_cfg();
        for (int k = 0; k < CFG_NUM; k++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(k);
            i_cfg_data <= cfg_plan[k];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // gains lean toward small values so the level lands inside 0..100 often
    function automatic logic [CFG_W-1:0] pick_gain();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 6))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return '0;
            3:       return r[15:0];
            default: return 16'(int'(r[9:0]) - 256);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_target();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'(int'(r[9:0]) - 512);
            default: return r[15:0];
        endcase
    endfunction

    // measurements cluster around the target to hit the band and zero error
    function automatic logic [MEAS_W-1:0] pick_meas(input logic [MEAS_W-1:0] tgt);
        logic [31:0] r;
        int          off;
        r   = $urandom;
        off = 0;
        case ($urandom_range(0, 9))
            0, 1, 2: off = int'($urandom_range(0, 12)) - 6;
            3, 4, 5: off = int'($urandom_range(0, 800)) - 400;
            6:       return 16'h7FFF;
            7:       return 16'h8000;
            default: return r[15:0];
        endcase
        return tgt + off[15:0];
    endfunction

    task automatic send_random();
        t_channel ch;
        ch = t_channel'($urandom_range(0, 1));
        if (ch == CH_DRIVE) send_sample(ch, pick_meas(cfg_plan[CFG_DRIVE_TARGET]));
        else                send_sample(ch, pick_meas(cfg_plan[CFG_TURN_TARGET]));
    endtask

    // receiver: random ready bursts, one long hold on request
    initial begin
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // sender and verdict
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_DRIVE_KP;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_channel     <= CH_DRIVE;
        i_measurement <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset gains are zero: level stays 0, zero error only at measurement 0
        send_sample(CH_DRIVE, 16'h0000);
        send_sample(CH_TURN,  16'h8000);
        send_sample(CH_DRIVE, 16'h7FFF);
        drain();

        // unit-ish drive gains, extreme turn gains and targets
        cfg_plan[CFG_DRIVE_KP]     = 16'h0100;
        cfg_plan[CFG_DRIVE_KI]     = 16'h0008;
        cfg_plan[CFG_DRIVE_KD]     = 16'h0040;
        cfg_plan[CFG_DRIVE_TARGET] = 16'h0000;
        cfg_plan[CFG_TURN_KP]      = 16'h7FFF;
        cfg_plan[CFG_TURN_KI]      = 16'h8000;
        cfg_plan[CFG_TURN_KD]      = 16'h7FFF;
        cfg_plan[CFG_TURN_TARGET]  = 16'h7FFF;
        apply_cfg();
        send_sample(CH_DRIVE, 16'h0000);   // exactly on target
        send_sample(CH_DRIVE, 16'hFFFD);   // error at the band edge, integral cleared
        send_sample(CH_DRIVE, 16'h0003);   // negative edge of the band, integral cleared
        send_sample(CH_DRIVE, 16'hFFFC);   // just outside the band, starts integrating
        maybe_gap();
        send_sample(CH_DRIVE, 16'hFFCE);   // mid-range level
        send_sample(CH_DRIVE, 16'hFF38);   // large sum, clamps to the top
        send_sample(CH_DRIVE, 16'h7FFF);   // big negative error, level 0
        send_sample(CH_TURN,  16'h8000);   // largest positive error
        send_sample(CH_TURN,  16'h7FFF);   // on target right after it
        send_sample(CH_TURN,  16'h7FFB);   // error of four
        send_sample(CH_TURN,  16'h7FFC);   // error of three
        drain();

        // opposite extremes: largest negative error and largest derivative
        cfg_plan[CFG_DRIVE_KP]     = 16'h8000;
        cfg_plan[CFG_DRIVE_KI]     = 16'h7FFF;
        cfg_plan[CFG_DRIVE_KD]     = 16'h8000;
        cfg_plan[CFG_DRIVE_TARGET] = 16'h8000;
        cfg_plan[CFG_TURN_KP]      = 16'h0000;
        cfg_plan[CFG_TURN_KI]      = 16'h0000;
        cfg_plan[CFG_TURN_KD]      = 16'h7FFF;
        cfg_plan[CFG_TURN_TARGET]  = 16'h8000;
        apply_cfg();
        send_sample(CH_DRIVE, 16'h7FFF);
        send_sample(CH_DRIVE, 16'h8000);
        send_sample(CH_TURN,  16'h7FFF);
        send_sample(CH_TURN,  16'h8000);
        send_sample(CH_TURN,  16'h7FFF);
        drain();

        // long integration: drive climbs toward the top of the sum range,
        // turn falls toward the bottom; kp works against ki on both loops
        cfg_plan[CFG_DRIVE_KP]     = 16'h8000;
        cfg_plan[CFG_DRIVE_KI]     = 16'h0001;
        cfg_plan[CFG_DRIVE_KD]     = 16'h0000;
        cfg_plan[CFG_DRIVE_TARGET] = 16'h7FFF;
        cfg_plan[CFG_TURN_KP]      = 16'h8000;
        cfg_plan[CFG_TURN_KI]      = 16'h0001;
        cfg_plan[CFG_TURN_KD]      = 16'h0000;
        cfg_plan[CFG_TURN_TARGET]  = 16'h8000;
        apply_cfg();
        no_idle = 1'b1;
        for (int n = 0; n < SAT_PAIRS; n++) begin
            send_sample(CH_DRIVE, 16'h8000);
            send_sample(CH_TURN,  16'h7FFF);
        end
        // step back inside the band to clear both large sums
        send_sample(CH_DRIVE, 16'h7FFE);
        send_sample(CH_TURN,  16'h8001);
        no_idle = 1'b0;

        // random phases, each with a fresh register file
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            for (int k = 0; k < CFG_NUM; k++) cfg_plan[k] = pick_gain();
            cfg_plan[CFG_DRIVE_TARGET] = pick_target();
            cfg_plan[CFG_TURN_TARGET]  = pick_target();
            apply_cfg();
            // the last phase runs flat out on both sides
            no_idle = (p == NUM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 0) begin
                    // receiver holds off while samples keep coming
                    hold_req = 1'b1;
                    repeat (BURST_ITEMS) send_random();
                end
                if (p == 3 && n == PHASE_ITEMS / 2) drain();
                send_random();
                maybe_gap();
            end
        end
        drain();

        if (mismatches == 0) begin
            $display("PASS dual_pid_drive_turn_controller");
        end else begin
            $display("FAIL dual_pid_drive_turn_controller");
        end
        $finish;
    end

endmodule
